FILE: rtl/detection_box_filter_macros.svh
// Assertion macros for the detection box filter.
`ifndef DETECTION_BOX_FILTER_MACROS_SVH
`define DETECTION_BOX_FILTER_MACROS_SVH

`ifndef SYNTHESIS

`define DBF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("detection_box_filter: check failed");

`define DBF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("detection_box_filter: check failed");

`else

`define DBF_ASSERT_IMP(lbl, ck, rn, ante, cons)

`define DBF_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

FILE: rtl/dbf_pkg.sv
// Types, constants and helpers shared by the detection box filter modules.
package dbf_pkg;

	localparam int MAX_CLASSES_DEF = 16;
	localparam int ALU_W = 17;

	localparam logic [15:0] SCORE_THR_RST = 16'd16384;
	localparam logic [9:0]  MAX_OBJ_RST   = 10'd300;
	localparam logic [4:0]  CLASS_CNT_RST = 5'd0;
	localparam logic [14:0] MIN_EXT_RST   = 15'd1;
	localparam logic signed [15:0] Q14_ONE = 16'sd16384;

	typedef enum logic [1:0] {
		REG_SCORE_THR = 2'd0,
		REG_MAX_OBJ   = 2'd1,
		REG_CLASS_CNT = 2'd2,
		REG_MIN_EXT   = 2'd3
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_BOX   = 1'b0,
		OP_ENTRY = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_SCORE,
		SQ_DX,
		SQ_DXC,
		SQ_DY,
		SQ_DYC,
		SQ_CNT,
		SQ_READ,
		SQ_MATCH,
		SQ_THR,
		SQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [15:0] min_score;
		logic [9:0]  max_objects;
		logic [4:0]  class_count;
		logic [14:0] min_extent;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
		logic [15:0]        score;
		logic [7:0]         class_index;
		logic               last;
	} box_t;

	typedef struct packed {
		logic [8:0]  label;
		logic [7:0]  class_id;
		logic [15:0] threshold;
	} entry_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  slot;
		entry_t      data;
	} ent_wr_t;

	typedef struct packed {
		logic        idle;
		logic        res_valid;
	} seq_status_t;

	typedef struct packed {
		logic        accepted;
		logic [7:0]  object_type;
		logic [15:0] confidence;
		logic [14:0] x_min;
		logic [14:0] y_min;
		logic [14:0] x_max;
		logic [14:0] y_max;
		logic [9:0]  object_count;
		logic        end_of_frame;
	} res_t;

	// clamp a Q2.14 value to [0, 1.0]
	function automatic logic [14:0] clamp_unit(input logic signed [15:0] v);
		logic [14:0] r;
		if (v < 16'sd0) begin
			r = 15'd0;
		end else if (v > Q14_ONE) begin
			r = Q14_ONE[14:0];
		end else begin
			r = v[14:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/detection_box_filter.sv
// Box filter: each box item walks the check states, then searches the class entries
// one at a time (read, then match); one shared ALU and one table read port pace it.
// Class table write items are taken whenever the filter is idle and give no result.
// A result sits in an output register, so the next box can start before it is taken.
// Reset (arst_n low) restores register defaults and clears the object count;
// class table contents are undefined until written.
`include "detection_box_filter_macros.svh"

module detection_box_filter #(
	parameter int MAX_CLASSES = dbf_pkg::MAX_CLASSES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// corner_x1, corner_y1, corner_x2, corner_y2, box_score, class_index,
	// entry_slot, entry_label, entry_class_id, entry_threshold
	input  logic [127:0] s_tdata,
	input  logic         s_tuser,   // operation
	input  logic         s_tlast,   // last_box
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// object_type, confidence, x_min, y_min, x_max, y_max, object_count
	output logic [95:0]  m_tdata,
	output logic         m_tuser,   // accepted
	output logic         m_tlast    // end_of_frame
);
	import dbf_pkg::*;

	cfg_t        cfg_q;
	seq_status_t status;
	res_t        res;
	box_t        box;
	ent_wr_t     ent_wr;

	logic        cfg_wr;
	logic        in_fire;
	logic        start;
	logic        res_ready;
	logic        m_tvalid_q;
	logic [95:0] m_tdata_q;
	logic        m_tuser_q;
	logic        m_tlast_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_score   <= SCORE_THR_RST;
			cfg_q.max_objects <= MAX_OBJ_RST;
			cfg_q.class_count <= CLASS_CNT_RST;
			cfg_q.min_extent  <= MIN_EXT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_SCORE_THR: cfg_q.min_score   <= pwdata[15:0];
				REG_MAX_OBJ:   cfg_q.max_objects <= pwdata[9:0];
				REG_CLASS_CNT: cfg_q.class_count <= pwdata[4:0];
				REG_MIN_EXT:   cfg_q.min_extent  <= pwdata[14:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_SCORE_THR: prdata = {16'd0, cfg_q.min_score};
			REG_MAX_OBJ:   prdata = {22'd0, cfg_q.max_objects};
			REG_CLASS_CNT: prdata = {27'd0, cfg_q.class_count};
			REG_MIN_EXT:   prdata = {17'd0, cfg_q.min_extent};
		endcase
	end

	// input request decode
	assign s_tready = status.idle;
	assign in_fire  = s_tvalid && s_tready;
	assign start    = in_fire && (op_t'(s_tuser) == OP_BOX);

	assign box.x1          = s_tdata[15:0];
	assign box.y1          = s_tdata[31:16];
	assign box.x2          = s_tdata[47:32];
	assign box.y2          = s_tdata[63:48];
	assign box.score       = s_tdata[79:64];
	assign box.class_index = s_tdata[87:80];
	assign box.last        = s_tlast;

	assign ent_wr.en              = in_fire && (op_t'(s_tuser) == OP_ENTRY);
	assign ent_wr.slot            = s_tdata[91:88];
	assign ent_wr.data.label      = s_tdata[100:92];
	assign ent_wr.data.class_id   = s_tdata[108:101];
	assign ent_wr.data.threshold  = s_tdata[124:109];

	dbf_seq #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.box       (box),
		.cfg       (cfg_q),
		.ent_wr    (ent_wr),
		.res_ready (res_ready),
		.status    (status),
		.res       (res)
	);

	// output register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (status.res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.res_valid && res_ready) begin
			m_tdata_q <= {2'd0, res.object_count, res.y_max, res.x_max, res.y_min,
				res.x_min, res.confidence, res.object_type};
			m_tuser_q <= res.accepted;
			m_tlast_q <= res.end_of_frame;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`DBF_ASSERT_NEXT(a_box_busy, clk, arst_n, in_fire && !s_tuser, !s_tready)
	`DBF_ASSERT_NEXT(a_entry_stays_ready, clk, arst_n, in_fire && s_tuser, s_tready)
	`DBF_ASSERT_IMP(a_reject_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata[83:0] == 84'd0)
	`DBF_ASSERT_IMP(a_corner_order, clk, arst_n, m_tvalid && m_tuser,
		(m_tdata[38:24] <= m_tdata[68:54]) && (m_tdata[53:39] <= m_tdata[83:69]))

endmodule

FILE: rtl/dbf_alu.sv
// Shared subtract/compare unit used by the sequencer for its score, extent, count, label and threshold tests.
module dbf_alu (
	input  logic signed [dbf_pkg::ALU_W-1:0] a,
	input  logic signed [dbf_pkg::ALU_W-1:0] b,
	output logic signed [dbf_pkg::ALU_W:0]   diff,
	output logic                             neg,
	output logic                             zero
);
	import dbf_pkg::*;

	assign diff = {a[ALU_W-1], a} - {b[ALU_W-1], b};
	assign neg  = diff[ALU_W];
	assign zero = (diff == '0);

endmodule

FILE: rtl/dbf_class_table.sv
// Class table memory: one write port, one registered read port.
module dbf_class_table #(
	parameter int MAX_CLASSES = dbf_pkg::MAX_CLASSES_DEF,
	parameter int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
	input  logic             clk,
	input  dbf_pkg::ent_wr_t wr,
	input  logic [IDX_W-1:0] rd_addr,
	output dbf_pkg::entry_t  rd_data
);
	import dbf_pkg::*;

	localparam logic [8:0] DEPTH9 = 9'(MAX_CLASSES);

	entry_t     mem [MAX_CLASSES];
	logic [8:0] slot9;

	assign slot9 = {5'd0, wr.slot};

	// writes to slots beyond the table are dropped
	always_ff @(posedge clk) begin
		if (wr.en && (slot9 < DEPTH9)) begin
			mem[slot9[IDX_W-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/dbf_seq.sv
// Per-box sequencer: runs all checks and the class search through one shared ALU.
module dbf_seq #(
	parameter int MAX_CLASSES = dbf_pkg::MAX_CLASSES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  dbf_pkg::box_t        box,
	input  dbf_pkg::cfg_t        cfg,
	input  dbf_pkg::ent_wr_t     ent_wr,
	input  logic                 res_ready,
	output dbf_pkg::seq_status_t status,
	output dbf_pkg::res_t        res
);
	import dbf_pkg::*;

	localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam logic [8:0] MAXC9 = 9'(MAX_CLASSES);

	seq_state_t state_q, state_d;

	box_t              box_q;
	logic [15:0]       abs_q;
	logic              x_lt_q;
	logic              y_lt_q;
	logic              keep_q;
	logic [7:0]        type_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  n_q;
	logic [9:0]        kept_q;

	logic signed [ALU_W-1:0] alu_a, alu_b;
	logic signed [ALU_W:0]   alu_diff;
	logic signed [ALU_W:0]   alu_ndiff;
	logic                    alu_neg, alu_zero;

	entry_t      rd_data;
	logic [8:0]  want;
	logic [8:0]  cc9, n9;
	logic [9:0]  kept_new;
	logic signed [15:0] lo_x, hi_x, lo_y, hi_y;

	dbf_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.neg  (alu_neg),
		.zero (alu_zero)
	);

	dbf_class_table #(
		.MAX_CLASSES (MAX_CLASSES),
		.IDX_W       (IDX_W)
	) u_table (
		.clk     (clk),
		.wr      (ent_wr),
		.rd_addr (j_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign want      = {1'b0, box_q.class_index} + 9'd1;
	assign cc9       = {4'd0, cfg.class_count};
	assign n9        = (cc9 > MAXC9) ? MAXC9 : cc9;
	assign alu_ndiff = -alu_diff;
	assign kept_new  = kept_q + {9'd0, keep_q};

	// operand select for the shared ALU
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			SQ_SCORE: begin
				alu_a = {1'b0, box_q.score};
				alu_b = {1'b0, cfg.min_score};
			end
			SQ_DX: begin
				alu_a = {box_q.x1[15], box_q.x1};
				alu_b = {box_q.x2[15], box_q.x2};
			end
			SQ_DY: begin
				alu_a = {box_q.y1[15], box_q.y1};
				alu_b = {box_q.y2[15], box_q.y2};
			end
			SQ_DXC, SQ_DYC: begin
				alu_a = {1'b0, abs_q};
				alu_b = {2'b0, cfg.min_extent};
			end
			SQ_CNT: begin
				alu_a = {7'd0, kept_q};
				alu_b = {7'd0, cfg.max_objects};
			end
			SQ_MATCH: begin
				alu_a = {8'd0, rd_data.label};
				alu_b = {8'd0, want};
			end
			SQ_THR: begin
				alu_a = {1'b0, box_q.score};
				alu_b = {1'b0, rd_data.threshold};
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE:  if (start) state_d = SQ_SCORE;
			SQ_SCORE: state_d = alu_neg ? SQ_DONE : SQ_DX;
			SQ_DX:    state_d = SQ_DXC;
			SQ_DXC:   state_d = alu_neg ? SQ_DONE : SQ_DY;
			SQ_DY:    state_d = SQ_DYC;
			SQ_DYC:   state_d = alu_neg ? SQ_DONE : SQ_CNT;
			SQ_CNT:   state_d = alu_neg ? SQ_READ : SQ_DONE;
			SQ_READ:  state_d = (j_q >= n_q) ? SQ_DONE : SQ_MATCH;
			SQ_MATCH: state_d = alu_zero ? SQ_THR : SQ_READ;
			SQ_THR:   state_d = SQ_DONE;
			SQ_DONE:  if (res_ready) state_d = SQ_IDLE;
			default:  state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			kept_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_DONE && res_ready) begin
				kept_q <= box_q.last ? 10'd0 : kept_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					box_q  <= box;
					n_q    <= n9[CNT_W-1:0];
					j_q    <= '0;
					keep_q <= 1'b0;
					type_q <= '0;
				end
			end
			SQ_DX: begin
				abs_q  <= alu_neg ? alu_ndiff[15:0] : alu_diff[15:0];
				x_lt_q <= alu_neg;
			end
			SQ_DY: begin
				abs_q  <= alu_neg ? alu_ndiff[15:0] : alu_diff[15:0];
				y_lt_q <= alu_neg;
			end
			SQ_MATCH: begin
				if (!alu_zero) begin
					j_q <= j_q + CNT_W'(1);
				end
			end
			SQ_THR: begin
				keep_q <= !alu_neg;
				type_q <= rd_data.class_id;
			end
			default: begin
			end
		endcase
	end

	assign lo_x = x_lt_q ? box_q.x1 : box_q.x2;
	assign hi_x = x_lt_q ? box_q.x2 : box_q.x1;
	assign lo_y = y_lt_q ? box_q.y1 : box_q.y2;
	assign hi_y = y_lt_q ? box_q.y2 : box_q.y1;

	always_comb begin
		res.accepted     = keep_q;
		res.object_type  = keep_q ? type_q : 8'd0;
		res.confidence   = keep_q ? box_q.score : 16'd0;
		res.x_min        = keep_q ? clamp_unit(lo_x) : 15'd0;
		res.y_min        = keep_q ? clamp_unit(lo_y) : 15'd0;
		res.x_max        = keep_q ? clamp_unit(hi_x) : 15'd0;
		res.y_max        = keep_q ? clamp_unit(hi_y) : 15'd0;
		res.object_count = kept_new;
		res.end_of_frame = box_q.last;
	end

	assign status.idle      = (state_q == SQ_IDLE);
	assign status.res_valid = (state_q == SQ_DONE);

endmodule

FILE: sim/tb.sv
// Self-checking testbench for detection_box_filter: directed and random box and table requests.
module tb;
	import dbf_pkg::*;

	localparam int TABLE_DEPTH  = MAX_CLASSES_DEF;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int STUCK_LIMIT  = 3000;
	localparam int MAX_SHOWN    = 10;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// corner_x1, corner_y1, corner_x2, corner_y2, box_score, class_index,
	// entry_slot, entry_label, entry_class_id, entry_threshold
	logic [127:0] s_tdata = '0;
	logic         s_tuser = 1'b0;   // operation
	logic         s_tlast = 1'b0;   // last_box
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// object_type, confidence, x_min, y_min, x_max, y_max, object_count
	logic [95:0]  m_tdata;
	logic         m_tuser;          // accepted
	logic         m_tlast;          // end_of_frame

	// shadow copy of the block's registers, class table and frame count
	cfg_t   cfg_mirror = {SCORE_THR_RST, MAX_OBJ_RST, CLASS_CNT_RST, MIN_EXT_RST};
	entry_t class_table [TABLE_DEPTH];
	logic [9:0] frame_kept = '0;
	res_t   pending_results [$];

	int   err_count = 0;
	int   src_idle_pct = 0;
	int   sink_stall_pct = 0;
	int   stuck_cycles = 0;
	logic hold_on = 1'b0;
	event hold_start;

	detection_box_filter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic logic [14:0] unit_clip(int v);
		if (v < 0) return 15'd0;
		if (v > 16384) return 15'd16384;
		return 15'(v);
	endfunction

	function automatic res_t filter_box(box_t b);
		res_t       r;
		int         x1, y1, x2, y2, dx, dy, n;
		logic [8:0] want;
		logic       keep, searching;
		r = '0;
		keep = 1'b0;
		searching = 1'b1;
		x1 = $signed(b.x1);
		y1 = $signed(b.y1);
		x2 = $signed(b.x2);
		y2 = $signed(b.y2);
		dx = (x1 > x2) ? x1 - x2 : x2 - x1;
		dy = (y1 > y2) ? y1 - y2 : y2 - y1;
		want = {1'b0, b.class_index} + 9'd1;
		n = (cfg_mirror.class_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_mirror.class_count;
		if (b.score >= cfg_mirror.min_score && dx >= cfg_mirror.min_extent &&
				dy >= cfg_mirror.min_extent && frame_kept < cfg_mirror.max_objects) begin
			// only the first matching label decides
			for (int j = 0; j < n; j++) begin
				if (searching && class_table[j].label == want) begin
					searching = 1'b0;
					if (b.score >= class_table[j].threshold) begin
						keep = 1'b1;
						r.object_type = class_table[j].class_id;
					end
				end
			end
		end
		if (keep) begin
			frame_kept = frame_kept + 10'd1;
			r.accepted = 1'b1;
			r.confidence = b.score;
			r.x_min = unit_clip((x1 < x2) ? x1 : x2);
			r.y_min = unit_clip((y1 < y2) ? y1 : y2);
			r.x_max = unit_clip((x1 > x2) ? x1 : x2);
			r.y_max = unit_clip((y1 > y2) ? y1 : y2);
		end
		r.object_count = frame_kept;
		r.end_of_frame = b.last;
		if (b.last) frame_kept = '0;
		return r;
	endfunction

	function automatic string fmt_result(res_t r);
		return $sformatf("acc=%0d type=%0d conf=%0d x=%0d..%0d y=%0d..%0d cnt=%0d eof=%0d",
			r.accepted, r.object_type, r.confidence, r.x_min, r.x_max, r.y_min, r.y_max,
			r.object_count, r.end_of_frame);
	endfunction

	function automatic box_t make_box(int x1, int y1, int x2, int y2, int score, int cls,
			bit last);
		box_t b;
		b.x1 = 16'(x1);
		b.y1 = 16'(y1);
		b.x2 = 16'(x2);
		b.y2 = 16'(y2);
		b.score = 16'(score);
		b.class_index = 8'(cls);
		b.last = last;
		return b;
	endfunction

	function automatic entry_t make_entry(int label, int id, int thr);
		entry_t e;
		e.label = 9'(label);
		e.class_id = 8'(id);
		e.threshold = 16'(thr);
		return e;
	endfunction

	// mostly plausible boxes that reach the table search, some pure noise
	function automatic box_t shaped_box();
		box_t        b;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		b = raw[88:0];
		if ($urandom_range(9) < 7) begin
			b.x1 = 16'($urandom_range(0, 22000)) - 16'd3000;
			b.y1 = 16'($urandom_range(0, 22000)) - 16'd3000;
			b.x2 = b.x1 + 16'($urandom_range(0, 12000)) - 16'd6000;
			b.y2 = b.y1 + 16'($urandom_range(0, 12000)) - 16'd6000;
			b.score = 16'($urandom_range(20000, 65535));
			b.class_index = 8'($urandom_range(0, 23));
		end
		if ($urandom_range(15) == 0) b.x2 = b.x1 + 16'($urandom_range(0, 3));
		b.last = ($urandom_range(24) == 0);
		return b;
	endfunction

	function automatic entry_t shaped_entry();
		entry_t e;
		e.class_id = 8'($urandom);
		case ($urandom_range(7))
			0: e.label = 9'($urandom_range(0, 256));
			1: e.label = $urandom_range(1) ? 9'd256 : 9'd0;
			default: e.label = 9'($urandom_range(1, 24));
		endcase
		e.threshold = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 45000));
		return e;
	endfunction

	task automatic send_request(op_t op, box_t b, entry_t e, logic [3:0] slot);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tlast <= b.last;
		s_tdata <= {3'b000, e.threshold, e.class_id, e.label, slot, b.class_index, b.score,
			b.y2, b.x2, b.y1, b.x1};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_ENTRY) class_table[slot] = e;
		else pending_results.push_back(filter_box(b));
	endtask

	task automatic send_box(box_t b);
		send_request(OP_BOX, b, shaped_entry(), 4'($urandom));
	endtask

	// box fields of a table write are don't-care, so they carry random bits
	task automatic send_entry(logic [3:0] slot, entry_t e);
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		send_request(OP_ENTRY, raw[88:0], e, slot);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SCORE_THR: cfg_mirror.min_score = value[15:0];
			REG_MAX_OBJ:   cfg_mirror.max_objects = value[9:0];
			REG_CLASS_CNT: cfg_mirror.class_count = value[4:0];
			REG_MIN_EXT:   cfg_mirror.min_extent = value[14:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(int unsigned thr, int unsigned max_obj, int unsigned classes,
			int unsigned extent);
		drain_results();
		apb_write(REG_SCORE_THR, thr);
		apb_write(REG_MAX_OBJ, max_obj);
		apb_write(REG_CLASS_CNT, classes);
		apb_write(REG_MIN_EXT, extent);
	endtask

	task automatic check_result();
		res_t got, want;
		got.accepted = m_tuser;
		got.object_type = m_tdata[7:0];
		got.confidence = m_tdata[23:8];
		got.x_min = m_tdata[38:24];
		got.y_min = m_tdata[53:39];
		got.x_max = m_tdata[68:54];
		got.y_max = m_tdata[83:69];
		got.object_count = m_tdata[93:84];
		got.end_of_frame = m_tlast;
		if (pending_results.size() == 0) begin
			err_count++;
			if (err_count <= MAX_SHOWN) $display("unexpected result: %s", fmt_result(got));
		end else begin
			want = pending_results.pop_front();
			if (got.accepted !== want.accepted || got.object_type !== want.object_type ||
					got.confidence !== want.confidence || got.x_min !== want.x_min ||
					got.y_min !== want.y_min || got.x_max !== want.x_max ||
					got.y_max !== want.y_max || got.object_count !== want.object_count ||
					got.end_of_frame !== want.end_of_frame) begin
				err_count++;
				if (err_count <= MAX_SHOWN) begin
					$display("mismatch expected: %s", fmt_result(want));
					$display("           actual: %s", fmt_result(got));
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result();
		m_tready <= !hold_on && ($urandom_range(99) >= sink_stall_pct);
	end

	always begin
		@(hold_start);
		@(negedge clk);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_on = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// class_count is still 0 from reset, so nothing is searched
	task automatic test_reset_defaults();
		send_box(make_box(0, 0, 8000, 8000, 65535, 0, 1'b0));
		send_box(make_box(1000, 1000, 9000, 9000, 30000, 5, 1'b1));
	endtask

	task automatic test_table_load();
		for (int j = 0; j < TABLE_DEPTH - 2; j++)
			send_entry(4'(j), make_entry(j + 1, 8'h40 + 5 * j, 2000 * j));
		// duplicate label behind slot 2, and the widest label in the last slot
		send_entry(4'd14, make_entry(3, 8'hee, 0));
		send_entry(4'd15, make_entry(256, 8'hff, 65535));
	endtask

	task automatic test_class_match();
		apply_config(0, 1023, 16, 1);
		send_box(make_box(-32768, -32768, 32767, 32767, 65535, 0, 1'b0));
		send_box(make_box(12000, 9000, 3000, 100, 5000, 1, 1'b0));
		send_box(make_box(0, 0, 8000, 8000, 3000, 2, 1'b0));
		send_box(make_box(100, 200, 16384, 20000, 65535, 255, 1'b0));
		send_box(make_box(100, 200, 16384, 20000, 65534, 255, 1'b0));
		send_box(make_box(100, 200, 9000, 9000, 65535, 100, 1'b0));
		send_box(make_box(5000, 100, 5000, 9000, 65535, 0, 1'b0));
		send_box(make_box(-5, 300, 400, -7, 0, 0, 1'b1));
	endtask

	task automatic test_frame_limits();
		apply_config(65535, 2, 16, 0);
		send_box(make_box(7000, 7000, 7000, 9000, 65535, 0, 1'b0));
		send_box(make_box(1000, 1000, 9000, 9000, 65534, 0, 1'b0));
		send_box(make_box(1000, 1000, 9000, 9000, 65535, 13, 1'b0));
		send_box(make_box(1000, 1000, 9000, 9000, 65535, 0, 1'b1));
		apply_config(0, 0, 16, 1);
		send_box(make_box(1000, 1000, 9000, 9000, 65535, 0, 1'b1));
	endtask

	task automatic test_extent_limits();
		// class count beyond the table depth still searches all sixteen slots
		apply_config(0, 1023, 31, 32767);
		send_box(make_box(-32768, -32768, 32767, 32767, 65535, 255, 1'b0));
		send_box(make_box(-16384, 0, 16382, 32767, 65535, 255, 1'b0));
		send_box(make_box(-1, -1, 32766, 32766, 65535, 255, 1'b1));
		apply_config(16384, 300, 0, 1);
		send_box(make_box(1000, 1000, 9000, 9000, 65535, 0, 1'b1));
	endtask

	task automatic test_backpressure();
		apply_config(0, 1023, 16, 0);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		-> hold_start;
		repeat (60) send_box(shaped_box());
	endtask

	task automatic test_random_traffic(int src_pct, int sink_pct, int count);
		apply_config($urandom_range(0, 40000), $urandom_range(1) ? 1023 : $urandom_range(1, 12),
			$urandom_range(1, 16), $urandom_range(0, 600));
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		repeat (count) begin
			if ($urandom_range(99) < 8) send_entry(4'($urandom), shaped_entry());
			else send_box(shaped_box());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_table_load();
		test_class_match();
		test_frame_limits();
		test_extent_limits();
		test_backpressure();
		test_random_traffic(0, 0, 170);
		test_random_traffic(65, 0, 170);
		test_random_traffic(0, 65, 170);
		test_random_traffic(8, 8, 170);
		drain_results();
		if (err_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
